[rtl/sm64br_pkg.sv]
// Shared widths, request codes and mixing constants for the bounded SplitMix64 generator.
package sm64br_pkg;

	localparam int WORD_W = 64;
	localparam int ARG_W  = 32;
	localparam int HALF_W = 32;

	localparam logic [1:0] FUNC_RAW     = 2'd0;
	localparam logic [1:0] FUNC_BOUNDED = 2'd1;
	localparam logic [1:0] FUNC_PERCENT = 2'd2;
	localparam logic [1:0] FUNC_UNIT    = 2'd3;

	localparam logic [WORD_W-1:0] GOLDEN_STEP = 64'h9E37_79B9_7F4A_7C15;
	localparam logic [WORD_W-1:0] MIX_MUL_A   = 64'hBF58_476D_1CE4_E5B9;
	localparam logic [WORD_W-1:0] MIX_MUL_B   = 64'h94D0_49BB_1331_11EB;

	localparam logic [ARG_W-1:0] PERCENT_SCALE = 32'd100;
	localparam int               FRAC_SHIFT    = 11;

endpackage

[rtl/sm64br_mul.sv]
// Iterative 64x64 multiplier keeping the low 64 bits, one 32x32 product per cycle.
module sm64br_mul (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [sm64br_pkg::WORD_W-1:0] a,
	input  logic [sm64br_pkg::WORD_W-1:0] b,
	output logic                         done,
	output logic [sm64br_pkg::WORD_W-1:0] product
);
	import sm64br_pkg::*;

	logic                busy_q;
	logic                done_q;
	logic [1:0]          step_q;
	logic [WORD_W-1:0]   a_q;
	logic [WORD_W-1:0]   b_q;
	logic [WORD_W-1:0]   acc_q;
	logic [HALF_W-1:0]   op_x;
	logic [HALF_W-1:0]   op_y;
	logic [WORD_W-1:0]   prod;

	always_comb begin
		case (step_q)
			2'd0: begin
				op_x = a_q[HALF_W-1:0];
				op_y = b_q[HALF_W-1:0];
			end
			2'd1: begin
				op_x = a_q[HALF_W-1:0];
				op_y = b_q[WORD_W-1:HALF_W];
			end
			default: begin
				op_x = a_q[WORD_W-1:HALF_W];
				op_y = b_q[HALF_W-1:0];
			end
		endcase
		prod = {{HALF_W{1'b0}}, op_x} * {{HALF_W{1'b0}}, op_y};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= 2'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= 2'd0;
			end else if (busy_q) begin
				if (step_q == 2'd2) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					step_q <= 2'd0;
				end else begin
					step_q <= step_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
		end else if (busy_q) begin
			if (step_q == 2'd0) begin
				acc_q <= prod;
			end else begin
				acc_q <= acc_q + {prod[HALF_W-1:0], {HALF_W{1'b0}}};
			end
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

[rtl/sm64br_mod.sv]
// Restoring 64-by-32 remainder unit, one dividend bit per cycle.
module sm64br_mod (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [sm64br_pkg::WORD_W-1:0] dividend,
	input  logic [sm64br_pkg::ARG_W-1:0]  divisor,
	output logic                         done,
	output logic [sm64br_pkg::ARG_W-1:0]  remainder
);
	import sm64br_pkg::*;

	localparam int CNT_W = $clog2(WORD_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [WORD_W-1:0] dvd_q;
	logic [ARG_W-1:0]  dsr_q;
	logic [ARG_W-1:0]  rem_q;
	logic [ARG_W:0]    trial;
	logic [ARG_W:0]    diff;

	always_comb begin
		trial = {rem_q, dvd_q[WORD_W-1]};
		diff  = trial - {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(WORD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[WORD_W-2:0], 1'b0};
			if (trial >= {1'b0, dsr_q}) begin
				rem_q <= diff[ARG_W-1:0];
			end else begin
				rem_q <= trial[ARG_W-1:0];
			end
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

[rtl/splitmix64_bounded_random.sv]
// Top level of the bounded SplitMix64 generator: sequencer, state and output word.
// Usage:
//   cfg_valid/cfg_ready write seed, which reloads the generator state. The port
//   is ready only while the sequencer is idle and wins over a request that
//   arrives in the same cycle.
//   in_valid/in_ready take one request word (func, argument). in_ready is high
//   only while the sequencer is idle; one request is worked at a time.
//   out_valid/out_ready deliver one value word per request.
// Steps from accept to out_valid:
//   zero bound, zero percent or full percent: output load only, state untouched.
//   raw and unit: advance, two multiplies of three passes each through one
//   shared 32x32 multiplier, xor-shifts, output load.
//   bounded and percent: as raw, plus the bit-serial 64-by-32 remainder unit.
// A new request is taken the cycle after the result is loaded into the output
// register, even if that word is still waiting. If the receiver stalls while a
// word is held and the next result is done, the sequencer holds until the
// held word is taken.
// Reset clears the generator state to zero and empties the output register.
module splitmix64_bounded_random (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [sm64br_pkg::WORD_W-1:0] seed,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   func,
	input  logic [sm64br_pkg::ARG_W-1:0]  argument,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [sm64br_pkg::WORD_W-1:0] value
);
	import sm64br_pkg::*;

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_ADV  = 9'b000000010,
		ST_XS1  = 9'b000000100,
		ST_MULA = 9'b000001000,
		ST_XS2  = 9'b000010000,
		ST_MULB = 9'b000100000,
		ST_XS3  = 9'b001000000,
		ST_MOD  = 9'b010000000,
		ST_FIN  = 9'b100000000
	} seq_state_t;

	seq_state_t        state_q;
	logic [WORD_W-1:0] gen_q;
	logic [WORD_W-1:0] z_q;
	logic [WORD_W-1:0] res_q;
	logic [1:0]        func_q;
	logic [ARG_W-1:0]  arg_q;
	logic              out_valid_q;
	logic [WORD_W-1:0] value_q;

	logic              mul_start;
	logic [WORD_W-1:0] mul_a;
	logic [WORD_W-1:0] mul_b;
	logic              mul_done;
	logic [WORD_W-1:0] mul_p;
	logic              mod_start;
	logic [ARG_W-1:0]  mod_divisor;
	logic              mod_done;
	logic [ARG_W-1:0]  mod_rem;
	logic [WORD_W-1:0] z_final;
	logic              in_fire;
	logic              cfg_fire;
	logic              out_load;

	assign cfg_ready = (state_q == ST_IDLE);
	assign in_ready  = (state_q == ST_IDLE) && !cfg_valid;
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign in_fire   = in_valid && in_ready;
	assign out_load  = (state_q == ST_FIN) && (!out_valid_q || out_ready);

	assign z_final     = z_q ^ (z_q >> 31);
	assign mul_start   = (state_q == ST_XS1) || (state_q == ST_XS2);
	assign mul_a       = (state_q == ST_XS1) ? (z_q ^ (z_q >> 30)) : (z_q ^ (z_q >> 27));
	assign mul_b       = (state_q == ST_XS1) ? MIX_MUL_A : MIX_MUL_B;
	assign mod_start   = (state_q == ST_XS3) &&
		((func_q == FUNC_BOUNDED) || (func_q == FUNC_PERCENT));
	assign mod_divisor = (func_q == FUNC_BOUNDED) ? arg_q : PERCENT_SCALE;

	sm64br_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (mul_a),
		.b       (mul_b),
		.done    (mul_done),
		.product (mul_p)
	);

	sm64br_mod u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mod_start),
		.dividend  (z_final),
		.divisor   (mod_divisor),
		.done      (mod_done),
		.remainder (mod_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			gen_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cfg_fire) begin
						gen_q <= seed;
					end else if (in_fire) begin
						if ((func == FUNC_BOUNDED || func == FUNC_PERCENT) &&
								argument == '0) begin
							state_q <= ST_FIN;
						end else if (func == FUNC_PERCENT && argument >= PERCENT_SCALE) begin
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_ADV;
						end
					end
				end
				ST_ADV: begin
					gen_q   <= gen_q + GOLDEN_STEP;
					state_q <= ST_XS1;
				end
				ST_XS1: state_q <= ST_MULA;
				ST_MULA: begin
					if (mul_done) begin
						state_q <= ST_XS2;
					end
				end
				ST_XS2: state_q <= ST_MULB;
				ST_MULB: begin
					if (mul_done) begin
						state_q <= ST_XS3;
					end
				end
				ST_XS3: begin
					if (mod_start) begin
						state_q <= ST_MOD;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_MOD: begin
					if (mod_done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			func_q <= func;
			arg_q  <= argument;
			if (func == FUNC_PERCENT && argument >= PERCENT_SCALE) begin
				res_q <= WORD_W'(1);
			end else begin
				res_q <= '0;
			end
		end
		if (state_q == ST_ADV) begin
			z_q <= gen_q + GOLDEN_STEP;
		end
		if ((state_q == ST_MULA || state_q == ST_MULB) && mul_done) begin
			z_q <= mul_p;
		end
		if (state_q == ST_XS3) begin
			if (func_q == FUNC_UNIT) begin
				res_q <= z_final >> FRAC_SHIFT;
			end else begin
				res_q <= z_final;
			end
		end
		if (state_q == ST_MOD && mod_done) begin
			if (func_q == FUNC_BOUNDED) begin
				res_q <= {{(WORD_W-ARG_W){1'b0}}, mod_rem};
			end else begin
				res_q <= WORD_W'(mod_rem < arg_q);
			end
		end
		if (out_load) begin
			value_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign value     = value_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == ST_MULA || state_q == ST_MULB))
		else $error("multiplier finished outside a multiply step");

	assert property (@(posedge clk) disable iff (!arst_n)
		mod_done |-> (state_q == ST_MOD))
		else $error("remainder unit finished outside the modulo step");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (out_valid && state_q == ST_IDLE))
		else $error("result word not presented after load");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |=> $stable(gen_q) || $past(state_q == ST_ADV))
		else $error("generator state moved outside the advance step");

endmodule

[tb/tb_splitmix64_bounded_random.sv]
// Self-checking testbench for the bounded SplitMix64 generator: directed and random words.
`timescale 1ns / 1ps

module tb_splitmix64_bounded_random;
	import sm64br_pkg::*;

	localparam int  CYCLE_LIMIT  = 1000000;
	localparam int  WORDS_PER_PH = 160;
	localparam int  NUM_SEEDS    = 7;
	localparam int  CALM_PHASE   = 3;
	localparam int  HOLD_AT_WORD = 250;
	localparam int  HOLD_CYCLES  = 500;
	localparam int  MAX_REPORTS  = 10;

	typedef struct packed {
		logic [1:0]        f;
		logic [ARG_W-1:0]  a;
		logic              known;
		logic [WORD_W-1:0] v;
	} req_row_t;

	localparam int NUM_ROWS = 21;
	req_row_t req_rows [NUM_ROWS] = '{
		'{FUNC_RAW,     32'h0000_0000, 1'b1, 64'hE220_A839_7B1D_CDAF},
		'{FUNC_BOUNDED, 32'h0000_0000, 1'b1, 64'h0},
		'{FUNC_PERCENT, 32'h0000_0000, 1'b1, 64'h0},
		'{FUNC_PERCENT, 32'd100,       1'b1, 64'h1},
		'{FUNC_PERCENT, 32'hFFFF_FFFF, 1'b1, 64'h1},
		'{FUNC_PERCENT, 32'd101,       1'b1, 64'h1},
		'{FUNC_BOUNDED, 32'd1,         1'b1, 64'h0},
		'{FUNC_PERCENT, 32'd99,        1'b0, 64'h0},
		'{FUNC_PERCENT, 32'd1,         1'b0, 64'h0},
		'{FUNC_PERCENT, 32'd50,        1'b0, 64'h0},
		'{FUNC_BOUNDED, 32'hFFFF_FFFF, 1'b0, 64'h0},
		'{FUNC_BOUNDED, 32'h8000_0000, 1'b0, 64'h0},
		'{FUNC_BOUNDED, 32'd100,       1'b0, 64'h0},
		'{FUNC_BOUNDED, 32'd7,         1'b0, 64'h0},
		'{FUNC_BOUNDED, 32'd2,         1'b0, 64'h0},
		'{FUNC_UNIT,    32'hFFFF_FFFF, 1'b0, 64'h0},
		'{FUNC_UNIT,    32'h0000_0000, 1'b0, 64'h0},
		'{FUNC_RAW,     32'hFFFF_FFFF, 1'b0, 64'h0},
		'{FUNC_RAW,     32'h5555_5555, 1'b0, 64'h0},
		'{FUNC_UNIT,    32'hAAAA_AAAA, 1'b0, 64'h0},
		'{FUNC_PERCENT, 32'hFFFF_FF9B, 1'b1, 64'h1}
	};

	logic              clk;
	logic              arst_n;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [WORD_W-1:0] seed;
	logic              in_valid;
	logic              in_ready;
	logic [1:0]        func;
	logic [ARG_W-1:0]  argument;
	logic              out_valid;
	logic              out_ready;
	logic [WORD_W-1:0] value;

	logic [WORD_W-1:0] gen_state;
	logic [WORD_W-1:0] pending_values [$];
	logic [WORD_W-1:0] want_value;
	int                bad_words;
	int                words_seen;
	int                cycle_count;
	int                hold_left;
	bit                hold_done;
	bit                calm;

	splitmix64_bounded_random i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.seed      (seed),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.argument  (argument),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.value     (value)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// advance the generator and return the mixed word
	function automatic logic [WORD_W-1:0] draw_word();
		logic [WORD_W-1:0] z;
		gen_state = gen_state + GOLDEN_STEP;
		z = gen_state;
		z = (z ^ (z >> 30)) * MIX_MUL_A;
		z = (z ^ (z >> 27)) * MIX_MUL_B;
		return z ^ (z >> 31);
	endfunction

	function automatic logic [WORD_W-1:0] predict_value(input logic [1:0] f,
			input logic [ARG_W-1:0] a);
		logic [WORD_W-1:0] r;
		r = '0;
		case (f)
			FUNC_RAW: begin
				r = draw_word();
			end
			FUNC_BOUNDED: begin
				if (a != '0)
					r = draw_word() % {{(WORD_W-ARG_W){1'b0}}, a};
			end
			FUNC_PERCENT: begin
				if (a == '0)
					r = '0;
				else if (a >= PERCENT_SCALE)
					r = 64'd1;
				else
					r = ((draw_word() % 64'd100) < {32'd0, a}) ? 64'd1 : 64'd0;
			end
			default: begin
				r = draw_word() >> FRAC_SHIFT;
			end
		endcase
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 50)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 40);
	endfunction

	function automatic logic [ARG_W-1:0] rand_arg();
		case ($urandom_range(0, 9))
			0: return $urandom_range(0, 3);
			1: return $urandom_range(95, 105);
			2: return $urandom_range(1, 99);
			3: return 32'hFFFF_FFFF - $urandom_range(0, 2);
			4: return 32'h1 << $urandom_range(0, 31);
			5: return $urandom_range(0, 255);
			default: return $urandom;
		endcase
	endfunction

	task automatic send_word(input logic [1:0] f, input logic [ARG_W-1:0] a,
			input logic known, input logic [WORD_W-1:0] kv);
		int gap;
		logic [WORD_W-1:0] pv;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		func     <= f;
		argument <= a;
		do @(posedge clk); while (!in_ready);
		pv = predict_value(f, a);
		pending_values.insert(pending_values.size(), known ? kv : pv);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_values.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_seed(input logic [WORD_W-1:0] s);
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		seed      <= s;
		do @(posedge clk); while (!cfg_ready);
		gen_state = s;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic report(input logic [WORD_W-1:0] exp_v, input logic [WORD_W-1:0] got_v);
		bad_words++;
		if (bad_words <= MAX_REPORTS)
			$display("value mismatch at word %0d: expected %h got %h", words_seen, exp_v, got_v);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_values.size() == 0) begin
				bad_words++;
				if (bad_words <= MAX_REPORTS)
					$display("unexpected value word %h", value);
			end else begin
				want_value = pending_values.pop_front();
				if (value !== want_value)
					report(want_value, value);
			end
			words_seen++;
		end
	end

	// receiver: random stalls, one long hold to back the block up
	initial begin
		out_ready = 1'b0;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left == 0) begin
				if (!hold_done && words_seen >= HOLD_AT_WORD) begin
					hold_done = 1'b1;
					hold_left = HOLD_CYCLES;
				end else begin
					hold_left = pick_gap();
				end
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		logic [WORD_W-1:0] seeds [NUM_SEEDS];
		arst_n     = 1'b0;
		cfg_valid  = 1'b0;
		seed       = '0;
		in_valid   = 1'b0;
		func       = FUNC_RAW;
		argument   = '0;
		bad_words  = 0;
		words_seen = 0;
		calm       = 1'b0;
		gen_state  = '0;
		seeds[0] = 64'hFFFF_FFFF_FFFF_FFFF;
		seeds[1] = 64'h0;
		seeds[2] = 64'h1;
		seeds[3] = 64'h8000_0000_0000_0000;
		seeds[4] = {$urandom, $urandom};
		seeds[5] = {$urandom, $urandom};
		seeds[6] = {$urandom, $urandom};
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < NUM_ROWS; i++)
			send_word(req_rows[i].f, req_rows[i].a, req_rows[i].known, req_rows[i].v);

		for (int p = 0; p < NUM_SEEDS; p++) begin
			write_seed(seeds[p]);
			calm = (p == CALM_PHASE);
			for (int n = 0; n < WORDS_PER_PH; n++)
				send_word(2'($urandom_range(0, 3)), rand_arg(), 1'b0, '0);
		end

		drain();
		repeat (100) @(posedge clk);
		if (bad_words == 0 && pending_values.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
